// ===== design/bsdu_pkg.sv =====
`default_nettype none

package bsdu_pkg;

  // Result kind codes
  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_BECH32  = 2'd1;
  localparam logic [1:0] KIND_BECH32M = 2'd2;

  // BCH generator terms and the Bech32m residue
  localparam logic [29:0] GEN0          = 30'h3b6a57b2;
  localparam logic [29:0] GEN1          = 30'h26508e6d;
  localparam logic [29:0] GEN2          = 30'h1ea119fa;
  localparam logic [29:0] GEN3          = 30'h3d4233dd;
  localparam logic [29:0] GEN4          = 30'h2a1462b3;
  localparam logic [29:0] BECH32M_CONST = 30'h2bc830a3;
  localparam logic [29:0] RESIDUE_INIT  = 30'h1;

  // Which value feeds the checksum step in the cycle after a buffer read
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_HI,
    STEP_ZERO,
    STEP_LO,
    STEP_DATA
  } step_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_HI,
    ST_ZERO,
    ST_LO,
    ST_DATA,
    ST_DRAIN,
    ST_VERDICT,
    ST_READ
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic  take;
    logic  check;
    step_t issue;
    logic  ptr_zero;
    logic  ptr_data;
    logic  ptr_inc;
    logic  emit_verdict;
    logic  emit_read;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pre_ok;
    logic pre_end;
    logic data_end;
  } dp_stat_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= "A" && c <= "Z") r = c + 8'd32;
    return r;
  endfunction

  // Returns {in_set, value}
  function automatic logic [5:0] sym_decode(input logic [7:0] c);
    logic [7:0] lc;
    logic [5:0] r;
    lc = fold_lower(c);
    unique case (lc)
      "q":     r = {1'b1, 5'd0};
      "p":     r = {1'b1, 5'd1};
      "z":     r = {1'b1, 5'd2};
      "r":     r = {1'b1, 5'd3};
      "y":     r = {1'b1, 5'd4};
      "9":     r = {1'b1, 5'd5};
      "x":     r = {1'b1, 5'd6};
      "8":     r = {1'b1, 5'd7};
      "g":     r = {1'b1, 5'd8};
      "f":     r = {1'b1, 5'd9};
      "2":     r = {1'b1, 5'd10};
      "t":     r = {1'b1, 5'd11};
      "v":     r = {1'b1, 5'd12};
      "d":     r = {1'b1, 5'd13};
      "w":     r = {1'b1, 5'd14};
      "0":     r = {1'b1, 5'd15};
      "s":     r = {1'b1, 5'd16};
      "3":     r = {1'b1, 5'd17};
      "j":     r = {1'b1, 5'd18};
      "n":     r = {1'b1, 5'd19};
      "5":     r = {1'b1, 5'd20};
      "4":     r = {1'b1, 5'd21};
      "k":     r = {1'b1, 5'd22};
      "h":     r = {1'b1, 5'd23};
      "c":     r = {1'b1, 5'd24};
      "e":     r = {1'b1, 5'd25};
      "6":     r = {1'b1, 5'd26};
      "m":     r = {1'b1, 5'd27};
      "u":     r = {1'b1, 5'd28};
      "a":     r = {1'b1, 5'd29};
      "7":     r = {1'b1, 5'd30};
      "l":     r = {1'b1, 5'd31};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // One BCH polymod step
  function automatic logic [29:0] poly_step(input logic [29:0] chk, input logic [4:0] v);
    logic [4:0]  top;
    logic [29:0] nxt;
    top = chk[29:25];
    nxt = {chk[24:0], v};
    if (top[0]) nxt = nxt ^ GEN0;
    if (top[1]) nxt = nxt ^ GEN1;
    if (top[2]) nxt = nxt ^ GEN2;
    if (top[3]) nxt = nxt ^ GEN3;
    if (top[4]) nxt = nxt ^ GEN4;
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ===== design/bsdu_ram.sv =====
`default_nettype none

// Single write port, single registered read port
module bsdu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/bsdu_ctrl.sv =====
`default_nettype none

// Sequencer: append/read acceptance and the verdict passes
module bsdu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               in_action,
  input  wire logic               in_is_last,
  input  wire bsdu_pkg::dp_stat_t stat,
  output logic                    busy,
  output bsdu_pkg::ctl_cmd_t      cmd
);

  bsdu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsdu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsdu_pkg::ST_IDLE: begin
        if (start) begin
          if (in_action) state_nxt = bsdu_pkg::ST_READ;
          else if (in_is_last) state_nxt = bsdu_pkg::ST_CHECK;
        end
      end
      bsdu_pkg::ST_CHECK:
        state_nxt = stat.pre_ok ? bsdu_pkg::ST_HI : bsdu_pkg::ST_VERDICT;
      bsdu_pkg::ST_HI:
        if (stat.pre_end) state_nxt = bsdu_pkg::ST_ZERO;
      bsdu_pkg::ST_ZERO:
        state_nxt = bsdu_pkg::ST_LO;
      bsdu_pkg::ST_LO:
        if (stat.pre_end) state_nxt = bsdu_pkg::ST_DATA;
      bsdu_pkg::ST_DATA:
        if (stat.data_end) state_nxt = bsdu_pkg::ST_DRAIN;
      bsdu_pkg::ST_DRAIN:
        state_nxt = bsdu_pkg::ST_VERDICT;
      bsdu_pkg::ST_VERDICT:
        state_nxt = bsdu_pkg::ST_IDLE;
      bsdu_pkg::ST_READ:
        state_nxt = bsdu_pkg::ST_IDLE;
      default:
        state_nxt = bsdu_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy             = (state_r != bsdu_pkg::ST_IDLE);
    cmd              = '0;
    cmd.issue        = bsdu_pkg::STEP_NONE;
    unique case (state_r)
      bsdu_pkg::ST_IDLE:
        cmd.take = start;
      bsdu_pkg::ST_CHECK: begin
        cmd.check    = 1'b1;
        cmd.ptr_zero = 1'b1;
      end
      bsdu_pkg::ST_HI: begin
        cmd.issue    = bsdu_pkg::STEP_HI;
        cmd.ptr_zero = stat.pre_end;
        cmd.ptr_inc  = !stat.pre_end;
      end
      bsdu_pkg::ST_ZERO:
        cmd.issue = bsdu_pkg::STEP_ZERO;
      bsdu_pkg::ST_LO: begin
        cmd.issue    = bsdu_pkg::STEP_LO;
        cmd.ptr_data = stat.pre_end;
        cmd.ptr_inc  = !stat.pre_end;
      end
      bsdu_pkg::ST_DATA: begin
        cmd.issue   = bsdu_pkg::STEP_DATA;
        cmd.ptr_inc = 1'b1;
      end
      bsdu_pkg::ST_DRAIN: ;
      bsdu_pkg::ST_VERDICT:
        cmd.emit_verdict = 1'b1;
      bsdu_pkg::ST_READ:
        cmd.emit_read = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/bsdu_dp.sv =====
`default_nettype none

// String buffer, case/separator tracking, polymod engine and result registers
module bsdu_dp #(
  parameter int MAX_LEN = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bsdu_pkg::ctl_cmd_t cmd,
  input  wire logic               in_action,
  input  wire logic [7:0]         in_char_code,
  input  wire logic [6:0]         in_symbol_index,
  output bsdu_pkg::dp_stat_t      stat,
  output logic                    out_valid,
  output logic [1:0]              out_kind,
  output logic [6:0]              out_prefix_length,
  output logic [6:0]              out_payload_length,
  output logic [4:0]              out_symbol,
  output logic                    out_is_verdict
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  // String state
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    sep_r;
  logic             ovf_r, lower_r, upper_r, closed_r;
  logic [1:0]       verdict_r;
  // Verdict engine
  logic [29:0]      residue_r;
  logic             bad_r;
  logic [AW-1:0]    ptr_r;
  bsdu_pkg::step_t  tag_r;
  logic [6:0]       idx_r;
  // Result registers
  logic             out_valid_r, out_is_verdict_r;
  logic [1:0]       out_kind_r;
  logic [6:0]       out_prefix_r, out_payload_r;
  logic [4:0]       out_symbol_r;

  // Buffer port signals
  logic             ram_we;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  logic             appending;
  logic [CW-1:0]    eff_count;
  logic [AW-1:0]    eff_sep;
  logic             eff_ovf, eff_lower, eff_upper, room;
  logic             ch_lower, ch_upper;
  logic [LW:0]      sep_plus7;
  logic [LW-1:0]    prefix_full, payload_full, rd_sum;
  logic [7:0]       folded;
  logic [5:0]       dec;
  logic [4:0]       step_val;
  logic [1:0]       vk;

  // A new string starts on the first append after a verdict
  always_comb begin
    appending = cmd.take && !in_action;
    eff_count = closed_r ? '0 : count_r;
    eff_sep   = closed_r ? '0 : sep_r;
    eff_ovf   = closed_r ? 1'b0 : ovf_r;
    eff_lower = closed_r ? 1'b0 : lower_r;
    eff_upper = closed_r ? 1'b0 : upper_r;
    room      = eff_count < CW'(MAX_LEN);
    ch_lower  = (in_char_code >= "a") && (in_char_code <= "z");
    ch_upper  = (in_char_code >= "A") && (in_char_code <= "Z");
    ram_we    = appending && room;
  end

  // Lengths and pass bounds
  always_comb begin
    sep_plus7     = (LW + 1)'(sep_r) + (LW + 1)'(7);
    prefix_full   = LW'(sep_r);
    payload_full  = LW'(count_r) - LW'(sep_r) - LW'(7);
    rd_sum        = LW'(sep_r) + LW'(1) + LW'(in_symbol_index);
    ram_raddr     = cmd.take ? rd_sum[AW-1:0] : ptr_r;
    stat.pre_ok   = !ovf_r && !(lower_r && upper_r) && (sep_r != '0) &&
                    (sep_plus7 <= (LW + 1)'(count_r));
    stat.pre_end  = (ptr_r == sep_r - AW'(1));
    stat.data_end = ((LW'(ptr_r) + LW'(1)) == LW'(count_r));
  end

  // Checksum input selection
  always_comb begin
    folded = bsdu_pkg::fold_lower(ram_rdata);
    dec    = bsdu_pkg::sym_decode(ram_rdata);
    unique case (tag_r)
      bsdu_pkg::STEP_HI:   step_val = {2'b00, folded[7:5]};
      bsdu_pkg::STEP_LO:   step_val = folded[4:0];
      bsdu_pkg::STEP_DATA: step_val = dec[4:0];
      default:             step_val = 5'd0;
    endcase
  end

  // Verdict from the final residue
  always_comb begin
    priority if (bad_r)                              vk = bsdu_pkg::KIND_INVALID;
    else if (residue_r == bsdu_pkg::RESIDUE_INIT)    vk = bsdu_pkg::KIND_BECH32;
    else if (residue_r == bsdu_pkg::BECH32M_CONST)   vk = bsdu_pkg::KIND_BECH32M;
    else                                             vk = bsdu_pkg::KIND_INVALID;
  end

  bsdu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (eff_count[AW-1:0]),
    .wdata (in_char_code),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // String bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      sep_r     <= '0;
      ovf_r     <= 1'b0;
      lower_r   <= 1'b0;
      upper_r   <= 1'b0;
      closed_r  <= 1'b0;
      verdict_r <= bsdu_pkg::KIND_INVALID;
    end else begin
      if (appending) begin
        closed_r  <= 1'b0;
        verdict_r <= bsdu_pkg::KIND_INVALID;
        count_r   <= room ? eff_count + CW'(1) : eff_count;
        ovf_r     <= eff_ovf || !room;
        lower_r   <= eff_lower || (room && ch_lower);
        upper_r   <= eff_upper || (room && ch_upper);
        sep_r     <= (room && in_char_code == "1") ? eff_count[AW-1:0] : eff_sep;
      end
      if (cmd.emit_verdict) begin
        verdict_r <= vk;
        closed_r  <= 1'b1;
      end
    end
  end

  // Polymod engine: each step uses the buffer data in the cycle after its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r     <= bsdu_pkg::STEP_NONE;
      residue_r <= bsdu_pkg::RESIDUE_INIT;
      bad_r     <= 1'b0;
      ptr_r     <= '0;
    end else begin
      tag_r <= cmd.issue;
      if (tag_r != bsdu_pkg::STEP_NONE) begin
        residue_r <= bsdu_pkg::poly_step(residue_r, step_val);
        if (tag_r == bsdu_pkg::STEP_DATA && !dec[5]) bad_r <= 1'b1;
      end
      if (cmd.check) begin
        residue_r <= bsdu_pkg::RESIDUE_INIT;
        bad_r     <= !stat.pre_ok;
      end
      priority if (cmd.ptr_zero) ptr_r <= '0;
      else if (cmd.ptr_data)     ptr_r <= sep_r + AW'(1);
      else if (cmd.ptr_inc)      ptr_r <= ptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_action) idx_r <= in_symbol_index;
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_verdict || cmd.emit_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_verdict) begin
      out_is_verdict_r <= 1'b1;
      out_kind_r       <= vk;
      out_symbol_r     <= 5'd0;
      out_prefix_r     <= (vk != bsdu_pkg::KIND_INVALID) ? prefix_full[6:0] : '0;
      out_payload_r    <= (vk != bsdu_pkg::KIND_INVALID) ? payload_full[6:0] : '0;
    end else if (cmd.emit_read) begin
      out_is_verdict_r <= 1'b0;
      out_kind_r       <= verdict_r;
      if (verdict_r != bsdu_pkg::KIND_INVALID) begin
        out_prefix_r  <= prefix_full[6:0];
        out_payload_r <= payload_full[6:0];
        out_symbol_r  <= (LW'(idx_r) < payload_full) ? dec[4:0] : 5'd0;
      end else begin
        out_prefix_r  <= '0;
        out_payload_r <= '0;
        out_symbol_r  <= 5'd0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_prefix_length  = out_prefix_r;
  assign out_payload_length = out_payload_r;
  assign out_symbol         = out_symbol_r;
  assign out_is_verdict     = out_is_verdict_r;

endmodule

`default_nettype wire

// ===== design/bech32_string_decoder_unit.sv =====
`default_nettype none

// Bech32/Bech32m string decoder. A transaction is taken when start is high
// and busy is low. An append (in_action 0) leaves busy low and gives no
// result unless in_is_last is set. The closing append starts the verdict:
// busy stays high while the polymod walks the buffer RAM one character per
// cycle (prefix high bits, a zero, prefix low bits, then the data); a string
// that fails the length, case or separator checks skips the walk. A read
// (in_action 1) holds busy for one cycle while the buffer RAM returns the
// symbol. Each result sits on the out_ ports for exactly one cycle with
// out_valid high, in the first cycle that busy is low again; there is no
// way to hold it back, so the receiver must take it then. Characters beyond
// MAX_LEN are dropped and make the string invalid.
module bech32_string_decoder_unit #(
  parameter int MAX_LEN = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_action,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_is_last,
  input  wire logic [6:0] in_symbol_index,
  output logic            out_valid,
  output logic [1:0]      out_kind,
  output logic [6:0]      out_prefix_length,
  output logic [6:0]      out_payload_length,
  output logic [4:0]      out_symbol,
  output logic            out_is_verdict
);

  bsdu_pkg::ctl_cmd_t cmd;
  bsdu_pkg::dp_stat_t stat;

  bsdu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_action  (in_action),
    .in_is_last (in_is_last),
    .stat       (stat),
    .busy       (busy),
    .cmd        (cmd)
  );

  bsdu_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_action          (in_action),
    .in_char_code       (in_char_code),
    .in_symbol_index    (in_symbol_index),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_kind           (out_kind),
    .out_prefix_length  (out_prefix_length),
    .out_payload_length (out_payload_length),
    .out_symbol         (out_symbol),
    .out_is_verdict     (out_is_verdict)
  );

`ifndef SYNTHESIS
  // Results never come in adjacent cycles
  a_no_double_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on two adjacent cycles");

  // A read transaction answers with a non-verdict result once its READ state has passed
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action |=> ##1 (out_valid && !out_is_verdict))
    else $error("read result missing");

  // A closing append always starts the verdict sequence
  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_action && in_is_last |=> busy)
    else $error("closing append did not start verdict");

  // An invalid kind carries no lengths and no symbol
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == bsdu_pkg::KIND_INVALID) |->
      (out_symbol == 5'd0) && (out_prefix_length == 7'd0) &&
      (out_payload_length == 7'd0))
    else $error("invalid result carries data");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 5;
  localparam int BUF_DEPTH     = 128;
  localparam int ITEM_TARGET   = 1330;
  localparam int SETTLE_CYCLES = 400;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [29:0]  BECH32_CONST = 30'd1;
  localparam logic [255:0] ALPHABET     = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  localparam logic [149:0] GEN_TERMS    = {bsdu_pkg::GEN4, bsdu_pkg::GEN3, bsdu_pkg::GEN2,
                                           bsdu_pkg::GEN1, bsdu_pkg::GEN0};

  typedef enum logic {ACT_APPEND = 1'b0, ACT_READ = 1'b1} action_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_WRONG_SYMBOL,
    FLAW_MIXED_CASE,
    FLAW_FOREIGN_CHAR,
    FLAW_NO_SEPARATOR,
    FLAW_EMPTY_PREFIX,
    FLAW_SHORT_DATA,
    FLAW_TOO_LONG,
    FLAW_NOISE
  } flaw_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] prefix_len;
    logic [6:0] payload_len;
    logic [4:0] symbol;
    logic       is_verdict;
  } decode_result_t;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       start           = 1'b0;
  logic       in_action       = 1'b0;
  logic [7:0] in_char_code    = 8'h00;
  logic       in_is_last      = 1'b0;
  logic [6:0] in_symbol_index = 7'd0;
  logic       busy;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [6:0] out_prefix_length;
  logic [6:0] out_payload_length;
  logic [4:0] out_symbol;
  logic       out_is_verdict;

  // Predictor copy of the string state
  logic [7:0] str_mem [0:BUF_DEPTH-1];
  logic [7:0] calc_text [0:255];
  int         str_len       = 0;
  int         sep_at        = 0;
  bit         str_overflow  = 1'b0;
  bit         str_has_lower = 1'b0;
  bit         str_has_upper = 1'b0;
  bit         str_closed    = 1'b0;
  logic [1:0] held_kind     = bsdu_pkg::KIND_INVALID;

  decode_result_t awaited_results [$];
  int items_sent  = 0;
  int fault_count = 0;
  int read_tally  = 0;
  int verdict_tally [4];
  bit burst_mode  = 1'b0;

  bech32_string_decoder_unit #(.MAX_LEN(BUF_DEPTH)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_char_code       (in_char_code),
    .in_is_last         (in_is_last),
    .in_symbol_index    (in_symbol_index),
    .out_valid          (out_valid),
    .out_kind           (out_kind),
    .out_prefix_length  (out_prefix_length),
    .out_payload_length (out_payload_length),
    .out_symbol         (out_symbol),
    .out_is_verdict     (out_is_verdict)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [7:0] symbol_char(input int v);
    return ALPHABET[255 - 8*v -: 8];
  endfunction

  // Forces letters to one case, other bytes pass through
  function automatic logic [7:0] match_case(input logic [7:0] c, input bit upper);
    if (upper && c >= "a" && c <= "z") return c - 8'd32;
    if (!upper && c >= "A" && c <= "Z") return c + 8'd32;
    return c;
  endfunction

  // Symbol value of a byte in either case, -1 when outside the set
  function automatic int symbol_value(input logic [7:0] c);
    logic [7:0] lc;
    int found;
    lc = match_case(c, 1'b0);
    found = -1;
    for (int i = 31; i >= 0; i--)
      if (symbol_char(i) == lc) found = i;
    return found;
  endfunction

  function automatic logic [29:0] bch_step(input logic [29:0] acc, input logic [4:0] v);
    logic [29:0] r;
    r = {acc[24:0], v};
    for (int k = 0; k < 5; k++)
      if (acc[25 + k]) r = r ^ GEN_TERMS[30*k +: 30];
    return r;
  endfunction

  // Polymod over calc_text: prefix high bits, a zero, prefix low bits, data
  function automatic logic [29:0] text_residue(input int sep, input int len);
    logic [29:0] acc;
    logic [7:0]  lc;
    int v;
    acc = bsdu_pkg::RESIDUE_INIT;
    for (int i = 0; i < sep; i++) begin
      lc = match_case(calc_text[i], 1'b0);
      acc = bch_step(acc, {2'b00, lc[7:5]});
    end
    acc = bch_step(acc, 5'd0);
    for (int i = 0; i < sep; i++) begin
      lc = match_case(calc_text[i], 1'b0);
      acc = bch_step(acc, lc[4:0]);
    end
    for (int i = sep + 1; i < len; i++) begin
      v = symbol_value(calc_text[i]);
      acc = bch_step(acc, v[4:0]);
    end
    return acc;
  endfunction

  // Updates the string state for one accepted transaction, queues its result
  task automatic predict_transaction(input action_t act, input logic [7:0] ch,
                                     input logic last, input logic [6:0] idx);
    decode_result_t want;
    logic [29:0] res;
    int span, v;
    bit ok;
    if (act == ACT_APPEND) begin
      if (str_closed) begin
        str_len       = 0;
        sep_at        = 0;
        str_overflow  = 1'b0;
        str_has_lower = 1'b0;
        str_has_upper = 1'b0;
        str_closed    = 1'b0;
      end
      held_kind = bsdu_pkg::KIND_INVALID;
      if (str_len < BUF_DEPTH) begin
        str_mem[str_len] = ch;
        if (ch >= "a" && ch <= "z") str_has_lower = 1'b1;
        else if (ch >= "A" && ch <= "Z") str_has_upper = 1'b1;
        if (ch == "1") sep_at = str_len;
        str_len++;
      end else begin
        str_overflow = 1'b1;
      end
      // closing byte: structural checks, then the checksum
      if (last) begin
        ok = !str_overflow && !(str_has_lower && str_has_upper) &&
             sep_at != 0 && sep_at + 7 <= str_len;
        for (int i = sep_at + 1; i < str_len; i++)
          if (symbol_value(str_mem[i]) < 0) ok = 1'b0;
        if (ok) begin
          for (int i = 0; i < str_len; i++) calc_text[i] = str_mem[i];
          res = text_residue(sep_at, str_len);
          if (res == BECH32_CONST) held_kind = bsdu_pkg::KIND_BECH32;
          else if (res == bsdu_pkg::BECH32M_CONST) held_kind = bsdu_pkg::KIND_BECH32M;
        end
        str_closed = 1'b1;
      end
    end
    if (act == ACT_READ || last) begin
      want = '0;
      want.is_verdict = (act == ACT_APPEND);
      if (held_kind != bsdu_pkg::KIND_INVALID) begin
        span = str_len - sep_at - 7;
        want.kind        = held_kind;
        want.prefix_len  = sep_at[6:0];
        want.payload_len = span[6:0];
        if (act == ACT_READ && idx < span) begin
          v = symbol_value(str_mem[sep_at + 1 + idx]);
          want.symbol = v[4:0];
        end
      end
      awaited_results.insert(awaited_results.size(), want);
    end
  endtask

  // One transaction; start stays high when no gap follows
  task automatic send_item(input action_t act, input logic [7:0] ch,
                           input logic last, input logic [6:0] idx);
    int gap, pick;
    start           <= 1'b1;
    in_action       <= act;
    in_char_code    <= ch;
    in_is_last      <= last;
    in_symbol_index <= idx;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_transaction(act, ch, last, idx);
    items_sent++;
    if (burst_mode) begin
      gap = 0;
    end else begin
      pick = $urandom_range(0, 99);
      gap = pick < 50 ? 0 : pick < 92 ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_read(input logic [6:0] idx);
    send_item(ACT_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_item(ACT_APPEND, s[i], i == s.len() - 1, 7'($urandom_range(0, 127)));
  endtask

  task automatic flag_fault(input string what);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  // Result check: every strobed result against the oldest expectation
  always @(posedge clk) begin : result_check
    decode_result_t got, want;
    if (rst_n && out_valid !== 1'b0) begin
      got = {out_kind, out_prefix_length, out_payload_length, out_symbol, out_is_verdict};
      if (got.is_verdict) verdict_tally[got.kind]++;
      else read_tally++;
      if (awaited_results.size() == 0) begin
        flag_fault($sformatf("result with none outstanding: kind %0d verdict %0b",
                             got.kind, got.is_verdict));
      end else begin
        want = awaited_results.pop_front();
        if (got !== want)
          flag_fault({$sformatf("mismatch exp/got: kind %0d/%0d prefix %0d/%0d ",
                                want.kind, got.kind, want.prefix_len, got.prefix_len),
                      $sformatf("payload %0d/%0d symbol %0d/%0d verdict %0b/%0b",
                                want.payload_len, got.payload_len, want.symbol,
                                got.symbol, want.is_verdict, got.is_verdict)});
      end
    end
  end

  task automatic test_read_without_verdict();
    send_read(7'd0);
  endtask

  // Known good strings, upper-case Bech32 and lower-case Bech32m
  task automatic test_bech32_vector();
    send_text("A12UEL5L");
    send_read(7'd0);
  endtask

  task automatic test_bech32m_vector();
    send_text("a1lqfn3a");
    send_read(7'd127);
  endtask

  // Separator at the start, no separator with extreme bytes, read on an open string
  task automatic test_malformed_strings();
    send_text("1");
    send_item(ACT_APPEND, 8'hff, 1'b0, 7'd127);
    send_item(ACT_APPEND, 8'h00, 1'b1, 7'd0);
    send_item(ACT_APPEND, "a", 1'b0, 7'd0);
    send_read(7'd5);
    send_item(ACT_APPEND, "1", 1'b1, 7'd127);
  endtask

  // Checksummed strings with random content, a share of them damaged
  task automatic test_random_strings();
    logic [7:0]  word [$];
    logic [7:0]  c;
    logic [29:0] residue;
    flaw_t flaw;
    int pre_len, data_len, pick, pos, target, top;
    bit upper, flipped;
    while (items_sent < ITEM_TARGET) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      upper = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 15) == 0) begin
        pre_len = $urandom_range(1, 121);
        data_len = $urandom_range(0, 1) ? 121 - pre_len : $urandom_range(0, 121 - pre_len);
      end else begin
        pre_len = $urandom_range(1, 8);
        data_len = $urandom_range(0, 20);
      end

      // prefix, separator and data
      word.delete();
      for (int i = 0; i < pre_len; i++) begin
        pick = $urandom_range(0, 15);
        if (pick < 10) c = 8'("a" + $urandom_range(0, 25));
        else if (pick < 13) c = 8'("0" + $urandom_range(0, 9));
        else if (pick < 15) c = 8'($urandom_range(33, 126));
        else c = 8'($urandom_range(0, 255));
        word.insert(word.size(), match_case(c, upper));
      end
      word.insert(word.size(), "1");
      for (int i = 0; i < data_len; i++)
        word.insert(word.size(), symbol_char($urandom_range(0, 31)));

      // checksum over six zero symbols, then the chosen constant
      foreach (word[i]) calc_text[i] = word[i];
      for (int i = 0; i < 6; i++) calc_text[word.size() + i] = "q";
      residue = text_residue(pre_len, word.size() + 6) ^
                ($urandom_range(0, 1) ? bsdu_pkg::BECH32M_CONST : BECH32_CONST);
      for (int i = 5; i >= 0; i--)
        word.insert(word.size(), symbol_char(residue[5*i +: 5]));
      foreach (word[i]) word[i] = match_case(word[i], upper);

      // damage
      pick = $urandom_range(0, 99);
      flaw = pick < 50 ? FLAW_NONE : flaw_t'(1 + pick % 8);
      case (flaw)
        FLAW_WRONG_SYMBOL: begin
          pos = $urandom_range(pre_len + 1, word.size() - 1);
          word[pos] = match_case(symbol_char($urandom_range(0, 31)), upper);
        end
        FLAW_MIXED_CASE: begin
          pos = $urandom_range(0, word.size() - 1);
          flipped = 1'b0;
          for (int n = 0; n < word.size(); n++) begin
            c = word[(pos + n) % word.size()] | 8'h20;
            if (!flipped && c >= "a" && c <= "z") begin
              word[(pos + n) % word.size()] ^= 8'h20;
              flipped = 1'b1;
            end
          end
        end
        FLAW_FOREIGN_CHAR: begin
          pos = $urandom_range(pre_len + 1, word.size() - 1);
          case ($urandom_range(0, 4))
            0: c = "b";
            1: c = "i";
            2: c = "o";
            3: c = "1";
            default: c = 8'($urandom_range(128, 255));
          endcase
          word[pos] = match_case(c, upper);
        end
        FLAW_NO_SEPARATOR: word.delete(pre_len);
        FLAW_EMPTY_PREFIX: repeat (pre_len) c = word.pop_front();
        FLAW_SHORT_DATA: begin
          target = pre_len + 1 + $urandom_range(0, 5);
          while (word.size() > target) c = word.pop_back();
        end
        FLAW_TOO_LONG: begin
          target = $urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 8);
          while (word.size() < target)
            word.insert(word.size(), match_case(symbol_char($urandom_range(0, 31)), upper));
        end
        FLAW_NOISE: begin
          word.delete();
          repeat ($urandom_range(1, 20)) word.insert(word.size(), 8'($urandom_range(0, 255)));
        end
        default: ;
      endcase

      // the string, with the odd read while it is still open
      for (int i = 0; i < word.size(); i++) begin
        if ($urandom_range(0, 39) == 0) send_read(7'($urandom_range(0, 127)));
        send_item(ACT_APPEND, word[i], i == word.size() - 1, 7'($urandom_range(0, 127)));
      end

      // reads of the decoded payload, mostly at indices up to the string's length
      top = word.size() < 128 ? word.size() : 127;
      repeat ($urandom_range(0, 3))
        send_read(7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127) :
                                                 $urandom_range(0, top)));
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_read_without_verdict();
    test_bech32_vector();
    test_bech32m_vector();
    test_malformed_strings();
    test_random_strings();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d transactions: %0d Bech32 and %0d Bech32m strings decoded, %0d rejected.",
             items_sent, verdict_tally[bsdu_pkg::KIND_BECH32],
             verdict_tally[bsdu_pkg::KIND_BECH32M], verdict_tally[bsdu_pkg::KIND_INVALID]);
    $display("Checked %0d payload symbol reads; %0d faults seen.", read_tally, fault_count);
    if (fault_count == 0) begin
      $display("bech32_string_decoder_unit test passed");
    end else begin
      $display("bech32_string_decoder_unit test failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", awaited_results.size());
    $display("bech32_string_decoder_unit test failed");
    $finish;
  end

endmodule
